@@ sv/assert_macros.svh @@
// Assertion macros shared by the go-to-goal controller RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted
`define GTG_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gtg assertion failed");

// Check that also holds across reset
`define GTG_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gtg assertion failed");

`endif

@@ sv/gtg_pkg.sv @@
// Shared types, constants and the arctangent table of the go-to-goal controller.
// No dependencies; used by every module of the block.
package gtg_pkg;

   // Default parameter values
   localparam int FRAC_BITS     = 12;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;

   // Field and datapath widths
   localparam int GUARD_BITS = 8;
   localparam int POS_W      = 16;
   localparam int HEAD_W     = 15;
   localparam int TURN_W     = 15;
   localparam int DELTA_W    = POS_W + 1;
   localparam int XY_W       = 28;
   localparam int Z_W        = 35;
   localparam int DIST_W     = 17;
   localparam int INVK_W     = 31;
   localparam int PROD_W     = XY_W + INVK_W;

   localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic [INVK_W-1:0] INV_K_Q30  = 31'd652032874;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_GOAL_X        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GOAL_Y        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN          = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_LIMIT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ARRIVE_RADIUS = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_AIM_TOLERANCE = 3'd5;

   localparam logic [POS_W-1:0]  RST_GOAL_X        = 16'd4096;
   localparam logic [POS_W-1:0]  RST_GOAL_Y        = 16'd4096;
   localparam logic [POS_W-1:0]  RST_GAIN          = 16'd4096;
   localparam logic [POS_W-1:0]  RST_SPEED_LIMIT   = 16'd12288;
   localparam logic [POS_W-1:0]  RST_ARRIVE_RADIUS = 16'd410;
   localparam logic [TURN_W-1:0] RST_AIM_TOLERANCE = 15'd819;

   // One CORDIC pipeline slot
   typedef struct packed {
      logic                     vld;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic signed [HEAD_W-1:0] hd;
   } gtg_vec_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
      case (idx)
         0:  return 35'sd843314856;
         1:  return 35'sd497837829;
         2:  return 35'sd263043836;
         3:  return 35'sd133525158;
         4:  return 35'sd67021686;
         5:  return 35'sd33543515;
         6:  return 35'sd16775850;
         7:  return 35'sd8388437;
         8:  return 35'sd4194282;
         9:  return 35'sd2097149;
         10: return 35'sd1048575;
         11: return 35'sd524287;
         12: return 35'sd262143;
         13: return 35'sd131071;
         14: return 35'sd65535;
         15: return 35'sd32767;
         16: return 35'sd16383;
         17: return 35'sd8191;
         18: return 35'sd4095;
         19: return 35'sd2047;
         20: return 35'sd1023;
         21: return 35'sd511;
         22: return 35'sd255;
         23: return 35'sd127;
         default: return '0;
      endcase
   endfunction

endpackage

@@ sv/go_to_goal_drive_controller_unit.sv @@
// Top level of the go-to-goal drive controller: registers, CORDIC chain, output logic.
// Depends on gtg_pkg, gtg_front, gtg_cordic_stage, gtg_back and assert_macros.svh.
//
// Usage:
//  - Pose samples come in on the req_ channel (valid/stall); a transfer happens
//    when req_valid is high and req_stall is low.
//  - Each pose gives exactly one speed command on the rsp_ channel, in order.
//  - The pipeline has one entry stage, one register per CORDIC iteration and
//    three output stages.
//  - Throughput is one pose per cycle unless rsp_stall holds a result; the unrolled
//    CORDIC chain and the pipelined multipliers let a new pose enter on every clock.
//  - When the receiver holds rsp_stall with a result waiting, the whole pipeline
//    freezes and req_stall goes high.
//  - Synchronous reset empties the pipeline and loads the register defaults
//    (goal 1.0/1.0, gain 1.0, limit 3.0, arrive radius 0.1, tolerance 0.2).
//  - The csr_ port writes one register per cycle with csr_we; write only while
//    no pose is in flight. Unknown indexes are ignored.
`include "assert_macros.svh"

module go_to_goal_drive_controller_unit #(
   parameter int FRAC_BITS     = gtg_pkg::FRAC_BITS,
   parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   // pose input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gtg_pkg::POS_W-1:0]           req_pos_x,
   input  logic [gtg_pkg::POS_W-1:0]           req_pos_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0]   req_heading,
   // speed command output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gtg_pkg::POS_W-1:0]           rsp_linear_speed,
   output logic [gtg_pkg::TURN_W-1:0]          rsp_turn_speed,
   // configuration writes
   input  logic                                csr_we,
   input  logic [gtg_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NSTG = (CORDIC_STAGES < gtg_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                             : gtg_pkg::ATAN_LEN;

   // Configuration registers
   logic [gtg_pkg::POS_W-1:0]  goal_x_ff;
   logic [gtg_pkg::POS_W-1:0]  goal_y_ff;
   logic [gtg_pkg::POS_W-1:0]  gain_ff;
   logic [gtg_pkg::POS_W-1:0]  speed_limit_ff;
   logic [gtg_pkg::POS_W-1:0]  arrive_radius_ff;
   logic [gtg_pkg::TURN_W-1:0] aim_tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff        <= gtg_pkg::RST_GOAL_X;
         goal_y_ff        <= gtg_pkg::RST_GOAL_Y;
         gain_ff          <= gtg_pkg::RST_GAIN;
         speed_limit_ff   <= gtg_pkg::RST_SPEED_LIMIT;
         arrive_radius_ff <= gtg_pkg::RST_ARRIVE_RADIUS;
         aim_tolerance_ff <= gtg_pkg::RST_AIM_TOLERANCE;
      end else if (csr_we) begin
         case (csr_addr)
            gtg_pkg::REG_GOAL_X:        goal_x_ff        <= csr_wdata;
            gtg_pkg::REG_GOAL_Y:        goal_y_ff        <= csr_wdata;
            gtg_pkg::REG_GAIN:          gain_ff          <= csr_wdata;
            gtg_pkg::REG_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata;
            gtg_pkg::REG_ARRIVE_RADIUS: arrive_radius_ff <= csr_wdata;
            gtg_pkg::REG_AIM_TOLERANCE:
               aim_tolerance_ff <= csr_wdata[gtg_pkg::TURN_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: move unless a finished result is blocked
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   gtg_pkg::gtg_vec_type chain [0:NSTG];

   gtg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (req_valid),
      .pos_x   (req_pos_x),
      .pos_y   (req_pos_y),
      .heading (req_heading),
      .goal_x  (goal_x_ff),
      .goal_y  (goal_y_ff),
      .stg_out (chain[0])
   );

   // One registered CORDIC iteration per stage
   for (genvar gi = 0; gi < NSTG; gi++) begin : g_cordic
      gtg_cordic_stage #(
         .SHIFT (gi)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .stg_in_d (chain[gi]),
         .stg_out  (chain[gi+1])
      );
   end

   gtg_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .stg_in_d      (chain[NSTG]),
      .gain          (gain_ff),
      .speed_limit   (speed_limit_ff),
      .arrive_radius (arrive_radius_ff),
      .aim_tolerance (aim_tolerance_ff),
      .out_vld       (rsp_valid),
      .linear_speed  (rsp_linear_speed),
      .turn_speed    (rsp_turn_speed)
   );

   // Checks
   `GTG_ASSERT_RST(a_one_cmd, clock, reset, !(rsp_valid && |rsp_turn_speed && |rsp_linear_speed))
   `GTG_ASSERT_RST(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall))
   `GTG_ASSERT_ALL(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

@@ sv/gtg_front.sv @@
// Entry stage: goal minus pose, guard bits and the half-plane pre-rotation.
// Depends on gtg_pkg.
module gtg_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic [gtg_pkg::POS_W-1:0]       pos_x,
   input  logic [gtg_pkg::POS_W-1:0]       pos_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0] heading,
   input  logic [gtg_pkg::POS_W-1:0]       goal_x,
   input  logic [gtg_pkg::POS_W-1:0]       goal_y,
   output gtg_pkg::gtg_vec_type            stg_out
);

   localparam int PAD_W = gtg_pkg::XY_W - gtg_pkg::DELTA_W - gtg_pkg::GUARD_BITS;

   logic signed [gtg_pkg::DELTA_W-1:0] dx;
   logic signed [gtg_pkg::DELTA_W-1:0] dy;
   logic signed [gtg_pkg::XY_W-1:0]    x_ext;
   logic signed [gtg_pkg::XY_W-1:0]    y_ext;
   gtg_pkg::gtg_vec_type               stg_in;
   gtg_pkg::gtg_vec_type               stg_ff;

   // Vector toward the goal, scaled by the guard bits
   assign dx    = $signed({1'b0, goal_x}) - $signed({1'b0, pos_x});
   assign dy    = $signed({1'b0, goal_y}) - $signed({1'b0, pos_y});
   assign x_ext = {{PAD_W{dx[gtg_pkg::DELTA_W-1]}}, dx, {gtg_pkg::GUARD_BITS{1'b0}}};
   assign y_ext = {{PAD_W{dy[gtg_pkg::DELTA_W-1]}}, dy, {gtg_pkg::GUARD_BITS{1'b0}}};

   // Left half-plane: turn by pi so vectoring converges
   always_comb begin
      stg_in.vld = in_vld;
      stg_in.hd  = heading;
      if (dx[gtg_pkg::DELTA_W-1]) begin
         stg_in.x = -x_ext;
         stg_in.y = -y_ext;
         stg_in.z = dy[gtg_pkg::DELTA_W-1] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
      end else begin
         stg_in.x = x_ext;
         stg_in.y = y_ext;
         stg_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.vld <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_in;
      end
   end

   assign stg_out = stg_ff;

endmodule

@@ sv/gtg_cordic_stage.sv @@
// One registered vectoring CORDIC iteration with a fixed shift amount.
// Depends on gtg_pkg for the slot type and the arctangent table.
module gtg_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  gtg_pkg::gtg_vec_type stg_in_d,
   output gtg_pkg::gtg_vec_type stg_out
);

   localparam logic signed [gtg_pkg::Z_W-1:0] ATAN = gtg_pkg::atan_q30(SHIFT);

   logic signed [gtg_pkg::XY_W-1:0] x_sh;
   logic signed [gtg_pkg::XY_W-1:0] y_sh;
   gtg_pkg::gtg_vec_type            stg_in;
   gtg_pkg::gtg_vec_type            stg_ff;

   assign x_sh = stg_in_d.x >>> SHIFT;
   assign y_sh = stg_in_d.y >>> SHIFT;

   // Rotate toward y = 0, direction from the sign of y
   always_comb begin
      stg_in = stg_in_d;
      if (!stg_in_d.y[gtg_pkg::XY_W-1]) begin
         stg_in.x = stg_in_d.x + y_sh;
         stg_in.y = stg_in_d.y - x_sh;
         stg_in.z = stg_in_d.z + ATAN;
      end else begin
         stg_in.x = stg_in_d.x - y_sh;
         stg_in.y = stg_in_d.y + x_sh;
         stg_in.z = stg_in_d.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.vld <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_in;
      end
   end

   assign stg_out = stg_ff;

endmodule

@@ sv/gtg_back.sv @@
// Output stages: gain correction, bearing rounding, thresholds, speed and result register.
// Depends on gtg_pkg.
module gtg_back #(
   parameter int FRAC_BITS = gtg_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  gtg_pkg::gtg_vec_type          stg_in_d,
   input  logic [gtg_pkg::POS_W-1:0]     gain,
   input  logic [gtg_pkg::POS_W-1:0]     speed_limit,
   input  logic [gtg_pkg::POS_W-1:0]     arrive_radius,
   input  logic [gtg_pkg::TURN_W-1:0]    aim_tolerance,
   output logic                          out_vld,
   output logic [gtg_pkg::POS_W-1:0]     linear_speed,
   output logic [gtg_pkg::TURN_W-1:0]    turn_speed
);

   localparam int Z_W     = gtg_pkg::Z_W;
   localparam int ERR_W   = Z_W + 1;
   localparam int PROD_W  = gtg_pkg::PROD_W;
   localparam int DIST_W  = gtg_pkg::DIST_W;
   localparam int LIN_W   = DIST_W + gtg_pkg::POS_W;
   localparam int Z_SH    = 30 - FRAC_BITS;
   localparam int D_SH    = 30 + gtg_pkg::GUARD_BITS;
   localparam longint Z_RND_L = 64'sd1 <<< (Z_SH - 1);
   localparam longint D_RND_L = 64'sd1 <<< (D_SH - 1);
   localparam logic signed [Z_W-1:0]    Z_RND = Z_W'(Z_RND_L);
   localparam logic signed [PROD_W-1:0] D_RND = PROD_W'(D_RND_L);
   localparam logic [ERR_W-1:0] TURN_MAX = ERR_W'({gtg_pkg::TURN_W{1'b1}});

   // Stage 1: scale magnitude by 1/K, round bearing, subtract heading
   logic signed [Z_W-1:0]    bear;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ERR_W-1:0]  err_in;
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ERR_W-1:0]  err_ff;

   assign bear    = (stg_in_d.z + Z_RND) >>> Z_SH;
   assign prod_in = stg_in_d.x * $signed({1'b0, gtg_pkg::INV_K_Q30});
   assign err_in  = ERR_W'(bear) - ERR_W'(stg_in_d.hd);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= stg_in_d.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         err_ff  <= err_in;
      end
   end

   // Stage 2: distance, thresholds, gain product
   logic signed [PROD_W-1:0]     rnd;
   logic [DIST_W-1:0]            goal_dist;
   logic [ERR_W-1:0]             aerr;
   logic [LIN_W-1:0]             lin_prod_in;
   logic                         far_in;
   logic                         turn_in;
   logic [gtg_pkg::TURN_W-1:0]   aerr_sat_in;
   logic                         v2_ff;
   logic [LIN_W-1:0]             lin_prod_ff;
   logic                         far_ff;
   logic                         turn_ff;
   logic [gtg_pkg::TURN_W-1:0]   aerr_sat_ff;

   assign rnd  = prod_ff + D_RND;
   assign goal_dist = rnd[PROD_W-1] ? '0 : rnd[D_SH +: DIST_W];
   assign aerr = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign lin_prod_in = LIN_W'(goal_dist) * LIN_W'(gain);
   assign far_in      = goal_dist > DIST_W'(arrive_radius);
   assign turn_in     = aerr > ERR_W'(aim_tolerance);
   assign aerr_sat_in = (aerr > TURN_MAX) ? {gtg_pkg::TURN_W{1'b1}}
                                          : aerr[gtg_pkg::TURN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_prod_ff <= lin_prod_in;
         far_ff      <= far_in;
         turn_ff     <= turn_in;
         aerr_sat_ff <= aerr_sat_in;
      end
   end

   // Stage 3: clamp, pick stop / turn / drive, result register
   logic [LIN_W-1:0]           lin_sh;
   logic [gtg_pkg::POS_W-1:0]  lin_cl;
   logic [gtg_pkg::POS_W-1:0]  lin_in;
   logic [gtg_pkg::TURN_W-1:0] trn_in;
   logic                       vld_ff;
   logic [gtg_pkg::POS_W-1:0]  lin_ff;
   logic [gtg_pkg::TURN_W-1:0] trn_ff;

   assign lin_sh = lin_prod_ff >> FRAC_BITS;
   assign lin_cl = (lin_sh > LIN_W'(speed_limit)) ? speed_limit
                                                  : lin_sh[gtg_pkg::POS_W-1:0];

   always_comb begin
      lin_in = '0;
      trn_in = '0;
      if (far_ff) begin
         if (turn_ff) begin
            trn_in = aerr_sat_ff;
         end else begin
            lin_in = lin_cl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff <= lin_in;
         trn_ff <= trn_in;
      end
   end

   assign out_vld      = vld_ff;
   assign linear_speed = lin_ff;
   assign turn_speed   = trn_ff;

endmodule

@@ bench/go_to_goal_drive_controller_unit_test.sv @@
// Testbench for go_to_goal_drive_controller_unit: random and directed pose traffic,
// with a CORDIC-based predictor that checks every speed command in order.
// Depends on gtg_pkg and the RTL of the block.
module go_to_goal_drive_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gtg_pkg::*;

   // register indexes outside the map; writes to them must not land
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

   localparam int     ROTATIONS   = 24;
   localparam int     DRAIN_WAIT  = CORDIC_STAGES + 8;
   localparam int     LONG_HOLD   = 300;
   localparam longint PI_Q30_L    = 64'sd3373259426;
   localparam longint INV_K_L     = 64'sd652032874;
   localparam longint ARCTAN_Q30 [ROTATIONS] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   typedef struct {
      logic [POS_W-1:0]  linear_speed;
      logic [TURN_W-1:0] turn_speed;
   } speed_cmd_t;

   // Predicts the speed command of each pose and checks the block's commands in order
   class speed_cmd_board;
      logic [POS_W-1:0]  goal_x        = RST_GOAL_X;
      logic [POS_W-1:0]  goal_y        = RST_GOAL_Y;
      logic [POS_W-1:0]  gain          = RST_GAIN;
      logic [POS_W-1:0]  speed_limit   = RST_SPEED_LIMIT;
      logic [POS_W-1:0]  arrive_radius = RST_ARRIVE_RADIUS;
      logic [TURN_W-1:0] aim_tolerance = RST_AIM_TOLERANCE;
      speed_cmd_t        expected_cmds [$];
      int                errors = 0;

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_GOAL_X:        goal_x = data;
            REG_GOAL_Y:        goal_y = data;
            REG_GAIN:          gain = data;
            REG_SPEED_LIMIT:   speed_limit = data;
            REG_ARRIVE_RADIUS: arrive_radius = data;
            REG_AIM_TOLERANCE: aim_tolerance = data[TURN_W-1:0];
            default: ;
         endcase
      endfunction

      // vectoring CORDIC on (goal - pose): distance in Q5.12, bearing in Q3.12
      function void vector_to_goal(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                   output longint goal_dist, output longint bear);
         longint dx, dy, x, y, z, nx, ny;
         dx = longint'(goal_x) - longint'(px);
         dy = longint'(goal_y) - longint'(py);
         x = dx * 256;
         y = dy * 256;
         z = 0;
         // left half plane: pre-rotate by pi
         if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? PI_Q30_L : -PI_Q30_L;
         end
         for (int i = 0; i < CORDIC_STAGES && i < ROTATIONS; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z += ARCTAN_Q30[i];
            end else begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z -= ARCTAN_Q30[i];
            end
            x = nx;
            y = ny;
         end
         goal_dist = (x * INV_K_L + (64'sd1 <<< (29 + GUARD_BITS))) >>> (30 + GUARD_BITS);
         if (goal_dist < 0) goal_dist = 0;
         bear = (z + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      endfunction

      function speed_cmd_t predict_speed_cmd(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                             logic signed [HEAD_W-1:0] hd);
         speed_cmd_t cmd;
         longint goal_dist, bear, err, lin, turn;
         vector_to_goal(px, py, goal_dist, bear);
         err = bear - longint'(hd);
         if (err < 0) err = -err;
         lin = 0;
         turn = 0;
         if (goal_dist > longint'(arrive_radius)) begin
            if (err > longint'(aim_tolerance)) begin
               // turn in place
               turn = (err > 32767) ? 32767 : err;
            end else begin
               // drive, clamped to the limit
               lin = (goal_dist * longint'(gain)) >>> FRAC_BITS;
               if (lin > longint'(speed_limit)) lin = speed_limit;
            end
         end
         cmd.linear_speed = lin[POS_W-1:0];
         cmd.turn_speed = turn[TURN_W-1:0];
         return cmd;
      endfunction

      function void note_pose(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              logic signed [HEAD_W-1:0] hd);
         expected_cmds.push_back(predict_speed_cmd(px, py, hd));
      endfunction

      function void check_command(logic [POS_W-1:0] lin, logic [TURN_W-1:0] turn);
         speed_cmd_t want;
         if (expected_cmds.size() == 0) begin
            errors++;
            $error("speed command with none pending: linear_speed %0d turn_speed %0d",
                   lin, turn);
            return;
         end
         want = expected_cmds.pop_front();
         if (want.linear_speed !== lin) begin
            errors++;
            $error("linear_speed: expected %0d, actual %0d", want.linear_speed, lin);
         end
         if (want.turn_speed !== turn) begin
            errors++;
            $error("turn_speed: expected %0d, actual %0d", want.turn_speed, turn);
         end
      endfunction

      function int outstanding();
         return expected_cmds.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [POS_W-1:0]         req_pos_x = '0;
   logic [POS_W-1:0]         req_pos_y = '0;
   logic signed [HEAD_W-1:0] req_heading = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [POS_W-1:0]         rsp_linear_speed;
   logic [TURN_W-1:0]        rsp_turn_speed;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   speed_cmd_board board = new;
   int             rsp_hold_request = 0;

   go_to_goal_drive_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_heading      (req_heading),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_turn_speed   (rsp_turn_speed),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels; each transfer goes to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_pose(req_pos_x, req_pos_y, req_heading);
         if (rsp_valid && !rsp_stall)
            board.check_command(rsp_linear_speed, rsp_turn_speed);
      end
   end

   // Receiver: random stall before each transfer, eager stretches, one long hold-off
   initial begin : rsp_side
      int hold;
      int served;
      bit eager;
      served = 0;
      eager = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         hold = eager ? 0 : $urandom_range(0, 11);
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         served++;
         if (served % 40 == 0) eager = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : watchdog
      #12_000_000;
      $display("** go_to_goal_drive_controller_unit: FAILED **");
      $finish;
   end

   // One pose transfer; valid stays high into the next pose when there is no gap
   task automatic send_pose(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic signed [HEAD_W-1:0] hd, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      do @(posedge clock); while (req_stall);
   endtask

   // Close the channel and wait until every pending command has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // Writes all six registers plus the two unmapped indexes, back to back
   task automatic program_regs(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                               input logic [POS_W-1:0] kp, input logic [POS_W-1:0] vmax,
                               input logic [POS_W-1:0] rad, input logic [CSR_DATA_W-1:0] tol);
      logic [CSR_ADDR_W-1:0] idx [8];
      logic [CSR_DATA_W-1:0] val [8];
      idx = '{REG_SPARE_6, REG_GOAL_X, REG_GOAL_Y, REG_GAIN, REG_SPEED_LIMIT,
              REG_ARRIVE_RADIUS, REG_AIM_TOLERANCE, REG_SPARE_7};
      val = '{16'($urandom), gx, gy, kp, vmax, rad, tol, 16'($urandom)};
      foreach (idx[k]) begin
         csr_we <= 1'b1;
         csr_addr <= idx[k];
         csr_wdata <= val[k];
         board.write_reg(idx[k], val[k]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] clamp_pos(longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[POS_W-1:0];
   endfunction

   // Pose mix: near the goal, aimed at the goal, or anywhere
   task automatic random_pose(output logic [POS_W-1:0] px, output logic [POS_W-1:0] py,
                              output logic signed [HEAD_W-1:0] hd);
      longint goal_dist, bear, tol;
      int pick, reach;
      pick = $urandom_range(0, 9);
      px = 16'($urandom);
      py = 16'($urandom);
      hd = 15'($urandom);
      if (pick < 2) begin
         reach = 2 * int'(board.arrive_radius) + 16;
         px = clamp_pos(longint'(board.goal_x) + $urandom_range(0, 2 * reach) - reach);
         py = clamp_pos(longint'(board.goal_y) + $urandom_range(0, 2 * reach) - reach);
      end
      if (pick < 6) begin
         board.vector_to_goal(px, py, goal_dist, bear);
         tol = board.aim_tolerance;
         hd = 15'(bear + longint'($urandom_range(0, 2 * tol + 64)) - tol - 32);
      end
   endtask

   task automatic random_items(input int count, input bit no_gaps);
      logic [POS_W-1:0]         px, py;
      logic signed [HEAD_W-1:0] hd;
      bit                       stretch;
      stretch = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) stretch = ($urandom_range(0, 3) == 0);
         random_pose(px, py, hd);
         send_pose(px, py, hd, no_gaps || stretch);
      end
   endtask

   task automatic directed_items();
      logic [POS_W-1:0]         dir_x [16];
      logic [POS_W-1:0]         dir_y [16];
      logic signed [HEAD_W-1:0] dir_h [16];
      // pose on goal, corners, arrive boundary, left half plane both ways,
      // axis bearings, aim tolerance edge, most negative heading
      dir_x = '{4096, 0, 65535, 0, 3686, 3685, 65535, 65535,
                8192, 8192, 4096, 4096, 0, 0, 0, 65535};
      dir_y = '{4096, 0, 65535, 4096, 4096, 4096, 0, 8192,
                4096, 4096, 0, 8192, 4096, 4096, 4096, 0};
      dir_h = '{0, -16384, 16383, 0, 0, 0, 12868, -12868,
                12868, -12868, 6434, -6434, 819, 820, -16384, 0};
      foreach (dir_x[k]) send_pose(dir_x[k], dir_y[k], dir_h[k], 1'b0);
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults
      directed_items();
      random_items(150, 1'b0);

      // low extremes, then high extremes
      wait_drained();
      program_regs(1, 1, 0, 0, 0, 0);
      random_items(150, 1'b0);
      wait_drained();
      program_regs(49151, 49151, 16'hFFFF, 16'hFFFF, 0, 25736);
      random_items(200, 1'b0);

      // goal outside the field, huge radius, tolerance with the top bit dropped
      wait_drained();
      program_regs(16'hFFFF, 0, 16'hFFFF, 12288, 16'hFFFF, 16'hFFFF);
      random_items(100, 1'b0);
      wait_drained();
      program_regs(0, 49151, 8192, 20480, 1, 0);
      random_items(200, 1'b0);

      // random settings
      repeat (3) begin
         wait_drained();
         program_regs($urandom_range(1, 49151), $urandom_range(1, 49151),
                      16'($urandom), 16'($urandom), $urandom_range(0, 4096),
                      $urandom_range(0, 25736));
         random_items(200, 1'b0);
      end

      // back to defaults: receiver holds off while poses keep coming
      wait_drained();
      program_regs(RST_GOAL_X, RST_GOAL_Y, RST_GAIN, RST_SPEED_LIMIT,
                   RST_ARRIVE_RADIUS, 16'(RST_AIM_TOLERANCE));
      rsp_hold_request = LONG_HOLD;
      random_items(80, 1'b1);

      // sender pauses until everything is back, then carries on
      wait_drained();
      random_items(350, 1'b0);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("** go_to_goal_drive_controller_unit: PASSED **");
      end else begin
         $display("** go_to_goal_drive_controller_unit: FAILED **");
      end
      $finish;
   end

endmodule
